// ----- rtl/salru_pkg.sv -----
`timescale 1ns / 1ps

package salru_pkg;

    localparam int ADDR_W     = 24;
    localparam int MAX_WAYS   = 8;
    localparam int WAY_W      = $clog2(MAX_WAYS);
    localparam int WAYS_W     = 4;
    localparam int MAX_SETS   = 1024;
    localparam int SET_W      = $clog2(MAX_SETS);
    localparam int TAG_W      = ADDR_W;
    localparam int STAMP_W    = 32;
    localparam int OFFW_W     = 5;
    localparam int IDXW_W     = 4;
    localparam int SPLIT_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [OFFW_W-1:0] OFFSET_WIDTH_RST = 5'd2;
    localparam logic [IDXW_W-1:0] INDEX_WIDTH_RST  = 4'd6;
    localparam logic [WAYS_W-1:0] WAYS_IN_USE_RST  = 4'd1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_STORE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_WIDTH = 2'd0,
        CFG_INDEX_WIDTH  = 2'd1,
        CFG_WAYS_IN_USE  = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] address;
    } in_item_t;

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] way;
        logic             filled;
    } out_item_t;

    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } way_entry_t;

    typedef way_entry_t [MAX_WAYS-1:0] set_row_t;

    typedef struct packed {
        logic clear;
        logic capture;
        logic lookup;
        logic scan;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic lk_hit;
        logic is_store;
        logic one_way;
        logic scan_last;
        logic out_free;
    } status_t;

    // Invalid ways take part in the victim search with an age of zero.
    function automatic logic [STAMP_W-1:0] eff_stamp(input way_entry_t e);
        return e.valid ? e.stamp : '0;
    endfunction

endpackage

// ----- rtl/salru_ram.sv -----
`timescale 1ns / 1ps

module salru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/salru_ctrl.sv -----
`timescale 1ns / 1ps

module salru_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  salru_pkg::status_t status,
    output salru_pkg::cmd_t    cmd
);

    salru_pkg::state_t state_reg;
    salru_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= salru_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            salru_pkg::ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = salru_pkg::ST_IDLE;
                end
            end
            salru_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = salru_pkg::ST_LOOKUP;
                end
            end
            salru_pkg::ST_LOOKUP:
            begin
                // Only a load miss over more than one way needs the victim search.
                if (!status.lk_hit && !status.is_store && !status.one_way)
                begin
                    state_next = salru_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = salru_pkg::ST_WRITE;
                end
            end
            salru_pkg::ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = salru_pkg::ST_WRITE;
                end
            end
            salru_pkg::ST_WRITE:
            begin
                if (status.out_free)
                begin
                    state_next = salru_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = salru_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd         = '0;
        case (state_reg)
            salru_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            salru_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            salru_pkg::ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
            end
            salru_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            salru_pkg::ST_WRITE:
            begin
                cmd.commit = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/salru_dpath.sv -----
`timescale 1ns / 1ps

module salru_dpath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    input  logic [salru_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [salru_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  salru_pkg::in_item_t                   in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output salru_pkg::out_item_t                  out_data,
    input  salru_pkg::cmd_t                       cmd,
    output salru_pkg::status_t                    status
);

    localparam int ROW_W = $bits(salru_pkg::set_row_t);

    // Configuration registers
    logic [salru_pkg::OFFW_W-1:0] off_w_reg;
    logic [salru_pkg::IDXW_W-1:0] idx_w_reg;
    logic [salru_pkg::WAYS_W-1:0] ways_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_w_reg <= salru_pkg::OFFSET_WIDTH_RST;
            idx_w_reg <= salru_pkg::INDEX_WIDTH_RST;
            ways_reg  <= salru_pkg::WAYS_IN_USE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                salru_pkg::CFG_OFFSET_WIDTH: off_w_reg <= cfg_data[salru_pkg::OFFW_W-1:0];
                salru_pkg::CFG_INDEX_WIDTH:  idx_w_reg <= cfg_data[salru_pkg::IDXW_W-1:0];
                salru_pkg::CFG_WAYS_IN_USE:  ways_reg  <= cfg_data[salru_pkg::WAYS_W-1:0];
                default:                     ways_reg  <= ways_reg;
            endcase
        end
    end

    logic [salru_pkg::WAYS_W-1:0] ways_eff;

    always_comb
    begin
        if (ways_reg == '0)
        begin
            ways_eff = salru_pkg::WAYS_W'(1);
        end
        else if (ways_reg > salru_pkg::WAYS_W'(salru_pkg::MAX_WAYS))
        begin
            ways_eff = salru_pkg::WAYS_W'(salru_pkg::MAX_WAYS);
        end
        else
        begin
            ways_eff = ways_reg;
        end
    end

    // Address split; shifts past the top of the address give zero.
    logic [salru_pkg::ADDR_W-1:0]  shifted;
    logic [salru_pkg::SET_W-1:0]   set_mask;
    logic [salru_pkg::SET_W-1:0]   set_idx;
    logic [salru_pkg::SPLIT_W-1:0] split;
    logic [salru_pkg::TAG_W-1:0]   tag_in;

    always_comb
    begin
        shifted  = in_data.address >> off_w_reg;
        set_mask = ~({salru_pkg::SET_W{1'b1}} << idx_w_reg);
        set_idx  = shifted[salru_pkg::SET_W-1:0] & set_mask;
        split    = salru_pkg::SPLIT_W'(off_w_reg) + salru_pkg::SPLIT_W'(idx_w_reg);
        tag_in   = salru_pkg::TAG_W'(in_data.address >> split);
    end

    logic                          op_reg;
    logic [salru_pkg::SET_W-1:0]   set_reg;
    logic [salru_pkg::TAG_W-1:0]   tag_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= in_data.op;
            set_reg <= set_idx;
            tag_reg <= tag_in;
        end
    end

    // Clearing pass over every set after reset
    logic [salru_pkg::SET_W-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_addr_reg <= clr_addr_reg + salru_pkg::SET_W'(1);
        end
    end

    // Set memory: one row holds every way of a set.
    salru_pkg::set_row_t         rd_row;
    salru_pkg::set_row_t         new_row;
    logic [ROW_W-1:0]            rd_bits;
    logic                        wr_en;
    logic [salru_pkg::SET_W-1:0] wr_addr;
    logic [ROW_W-1:0]            wr_bits;

    assign rd_row = salru_pkg::set_row_t'(rd_bits);

    salru_ram #(
        .WIDTH (ROW_W),
        .DEPTH (salru_pkg::MAX_SETS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_bits),
        .rd_en   (cmd.capture),
        .rd_addr (set_idx),
        .rd_data (rd_bits)
    );

    // Tag compare across the ways in use, lowest way first.
    logic                        lk_hit;
    logic [salru_pkg::WAY_W-1:0] lk_way;

    always_comb
    begin
        lk_hit = 1'b0;
        lk_way = '0;
        for (int w = salru_pkg::MAX_WAYS - 1; w >= 0; w--)
        begin
            if ((salru_pkg::WAYS_W'(w) < ways_eff) && rd_row[w].valid &&
                (rd_row[w].tag == tag_reg))
            begin
                lk_hit = 1'b1;
                lk_way = salru_pkg::WAY_W'(w);
            end
        end
    end

    logic                          hit_reg;
    logic [salru_pkg::WAY_W-1:0]   hit_way_reg;
    logic [salru_pkg::WAY_W-1:0]   victim_reg;
    logic [salru_pkg::WAY_W-1:0]   scan_idx_reg;
    logic [salru_pkg::STAMP_W-1:0] low_reg;
    logic [salru_pkg::STAMP_W-1:0] cand;

    assign cand = salru_pkg::eff_stamp(rd_row[scan_idx_reg]);

    // The victim search walks one way per cycle; a strict compare keeps the lowest way on ties.
    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            hit_reg      <= lk_hit;
            hit_way_reg  <= lk_way;
            victim_reg   <= '0;
            scan_idx_reg <= salru_pkg::WAY_W'(1);
            low_reg      <= salru_pkg::eff_stamp(rd_row[0]);
        end
        else if (cmd.scan)
        begin
            scan_idx_reg <= scan_idx_reg + salru_pkg::WAY_W'(1);
            if (cand < low_reg)
            begin
                low_reg    <= cand;
                victim_reg <= scan_idx_reg;
            end
        end
    end

    logic [salru_pkg::STAMP_W-1:0] access_count_reg;
    logic [salru_pkg::STAMP_W-1:0] access_count_next;
    logic                          fill;

    assign access_count_next = access_count_reg + salru_pkg::STAMP_W'(1);
    assign fill              = !hit_reg && (op_reg == salru_pkg::OP_LOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            access_count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            access_count_reg <= access_count_next;
        end
    end

    always_comb
    begin
        new_row = rd_row;
        if (hit_reg)
        begin
            new_row[hit_way_reg].stamp = access_count_next;
        end
        else if (fill)
        begin
            new_row[victim_reg].valid = 1'b1;
            new_row[victim_reg].tag   = tag_reg;
            new_row[victim_reg].stamp = access_count_next;
        end
    end

    always_comb
    begin
        if (cmd.clear)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_bits = '0;
        end
        else
        begin
            wr_en   = cmd.commit && (hit_reg || fill);
            wr_addr = set_reg;
            wr_bits = ROW_W'(new_row);
        end
    end

    // Output register
    logic                 out_valid_reg;
    salru_pkg::out_item_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_data_reg.hit    <= hit_reg;
            out_data_reg.way    <= hit_reg ? hit_way_reg : (fill ? victim_reg : '0);
            out_data_reg.filled <= fill;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        status.clear_last = (clr_addr_reg == salru_pkg::SET_W'(salru_pkg::MAX_SETS - 1));
        status.lk_hit     = lk_hit;
        status.is_store   = (op_reg == salru_pkg::OP_STORE);
        status.one_way    = (ways_eff == salru_pkg::WAYS_W'(1));
        status.scan_last  = (salru_pkg::WAYS_W'(scan_idx_reg) ==
                             (ways_eff - salru_pkg::WAYS_W'(1)));
        status.out_free   = !out_valid_reg || out_ready;
    end

endmodule

// ----- rtl/set_assoc_cache_lru_tags_unit.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     in_data   (op, address)
// out       output     out_valid / out_ready   out_data  (hit, way, filled)
// cfg       input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One access at a time: a hit, a store or a single-way load goes from the lookup state
// straight to the write state; a load miss over W ways first runs the one-way-per-cycle
// victim search over the set row read from the set memory.
// After reset a clearing pass writes all 1024 set rows, one per cycle, before the first
// access is taken; configuration writes are taken throughout.
// A stalled result sits in the output register; the next access may be taken meanwhile.

module set_assoc_cache_lru_tags_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  salru_pkg::in_item_t                   in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output salru_pkg::out_item_t                  out_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [salru_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [salru_pkg::CFG_DATA_W-1:0]      cfg_data
);

    salru_pkg::cmd_t    cmd;
    salru_pkg::status_t status;

    assign cfg_ready = 1'b1;

    salru_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    salru_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ----- rtl/salru_checker.sv -----
`timescale 1ns / 1ps

module salru_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input salru_pkg::out_item_t out_data
);

    // A waiting result holds until its transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or vanished while stalled");

    // Accesses are handled one at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second access taken straight after the first");

    a_hit_not_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.hit && out_data.filled))
        else $error("result reports both hit and fill");

    // A store miss reports way zero.
    a_store_miss_way: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hit && !out_data.filled |-> out_data.way == '0)
        else $error("store miss reports a non-zero way");

endmodule

bind set_assoc_cache_lru_tags_unit salru_checker u_salru_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int SETTLE_CYCLES   = 16;
    localparam int IDLE_LIMIT      = 20000;
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 155;

    // The register index that no register answers to; writes to it must change nothing.
    localparam logic [salru_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        bit                               is_cfg;
        logic                             op;
        logic [salru_pkg::ADDR_W-1:0]     address;
        bit                               pinned;
        salru_pkg::out_item_t             outcome;
        logic [salru_pkg::CFG_DATA_W-1:0] off_v;
        logic [salru_pkg::CFG_DATA_W-1:0] idx_v;
        logic [salru_pkg::CFG_DATA_W-1:0] ways_v;
        bit                               spare;
    } plan_row_t;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    salru_pkg::in_item_t              in_data;
    logic                             out_valid;
    logic                             out_ready;
    salru_pkg::out_item_t             out_data;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [salru_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [salru_pkg::CFG_DATA_W-1:0] cfg_data;

    // Expectation typed into the table for the access currently offered.
    bit                               pin_next;
    salru_pkg::out_item_t             pin_value;
    bit                               steady;

    // Own copy of the tag store and its settings.
    bit                               held_valid [salru_pkg::MAX_SETS*salru_pkg::MAX_WAYS];
    bit [salru_pkg::ADDR_W-1:0]       held_tag   [salru_pkg::MAX_SETS*salru_pkg::MAX_WAYS];
    bit [salru_pkg::STAMP_W-1:0]      held_age   [salru_pkg::MAX_SETS*salru_pkg::MAX_WAYS];
    bit [salru_pkg::STAMP_W-1:0]      access_tick;
    logic [salru_pkg::OFFW_W-1:0]     off_bits  = salru_pkg::OFFSET_WIDTH_RST;
    logic [salru_pkg::IDXW_W-1:0]     idx_bits  = salru_pkg::INDEX_WIDTH_RST;
    logic [salru_pkg::WAYS_W-1:0]     assoc_reg = salru_pkg::WAYS_IN_USE_RST;

    salru_pkg::out_item_t             expected_outcomes [$];
    plan_row_t                        directed_plan [$];
    int                               fault_count;
    int                               idle_cycles;
    int                               hold_left;

    set_assoc_cache_lru_tags_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int pause_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Looks up one access and updates the tag store exactly as the block should.
    function automatic salru_pkg::out_item_t access_cache(input salru_pkg::in_item_t a);
        int unsigned                  ways_n;
        int unsigned                  split;
        int unsigned                  set_no;
        int unsigned                  base;
        int unsigned                  victim;
        logic [salru_pkg::ADDR_W-1:0] tag_v;
        bit [salru_pkg::STAMP_W-1:0]  low;
        bit [salru_pkg::STAMP_W-1:0]  age;
        salru_pkg::out_item_t         res;
        bit                           found;

        ways_n = 32'(assoc_reg);
        if (ways_n == 0)
            ways_n = 1;
        if (ways_n > salru_pkg::MAX_WAYS)
            ways_n = salru_pkg::MAX_WAYS;
        access_tick = access_tick + 1;
        split  = 32'(off_bits) + 32'(idx_bits);
        set_no = 32'(((64'(a.address) >> off_bits) & ((64'd1 << idx_bits) - 1))
                     % salru_pkg::MAX_SETS);
        tag_v  = (split >= salru_pkg::ADDR_W) ? '0 :
                 salru_pkg::ADDR_W'(a.address >> split);
        base   = set_no * salru_pkg::MAX_WAYS;
        res    = '0;
        found  = 1'b0;

        for (int w = 0; w < ways_n && !found; w++)
        begin
            if (held_valid[base+w] && held_tag[base+w] == tag_v)
            begin
                found   = 1'b1;
                res.hit = 1'b1;
                res.way = salru_pkg::WAY_W'(w);
            end
        end

        if (found)
        begin
            held_age[base+res.way] = access_tick;
        end
        else if (a.op == salru_pkg::OP_LOAD)
        begin
            // Invalid ways age as zero, and only a strictly older way displaces the choice.
            victim = 0;
            low    = held_valid[base] ? held_age[base] : '0;
            for (int w = 1; w < ways_n; w++)
            begin
                age = held_valid[base+w] ? held_age[base+w] : '0;
                if (age < low)
                begin
                    low    = age;
                    victim = w;
                end
            end
            held_valid[base+victim] = 1'b1;
            held_tag[base+victim]   = tag_v;
            held_age[base+victim]   = access_tick;
            res.way    = salru_pkg::WAY_W'(victim);
            res.filled = 1'b1;
        end
        return res;
    endfunction

    // Mostly a handful of tags over a handful of sets, so lines hit, age and get evicted.
    function automatic logic [salru_pkg::ADDR_W-1:0] make_address(
        input logic [salru_pkg::CFG_DATA_W-1:0] off_v,
        input logic [salru_pkg::IDXW_W-1:0]     idx_v);
        logic [63:0] full;
        int unsigned split;

        if ($urandom_range(0, 99) < 20)
            return salru_pkg::ADDR_W'($urandom());
        split = 32'(off_v) + 32'(idx_v);
        full  = (64'($urandom_range(0, 11)) << split)
              | (64'($urandom_range(0, 3)) << off_v)
              | (64'($urandom()) & ((64'd1 << off_v) - 1));
        return full[salru_pkg::ADDR_W-1:0];
    endfunction

    function automatic plan_row_t acc(input logic op,
                                      input logic [salru_pkg::ADDR_W-1:0] address);
        plan_row_t r;

        r         = '0;
        r.op      = op;
        r.address = address;
        return r;
    endfunction

    function automatic plan_row_t pin(input logic op,
                                      input logic [salru_pkg::ADDR_W-1:0] address,
                                      input salru_pkg::out_item_t outcome);
        plan_row_t r;

        r         = acc(op, address);
        r.pinned  = 1'b1;
        r.outcome = outcome;
        return r;
    endfunction

    function automatic plan_row_t setup(input logic [salru_pkg::CFG_DATA_W-1:0] off_v,
                                        input logic [salru_pkg::CFG_DATA_W-1:0] idx_v,
                                        input logic [salru_pkg::CFG_DATA_W-1:0] ways_v,
                                        input bit spare);
        plan_row_t r;

        r        = '0;
        r.is_cfg = 1'b1;
        r.off_v  = off_v;
        r.idx_v  = idx_v;
        r.ways_v = ways_v;
        r.spare  = spare;
        return r;
    endfunction

    task automatic settle();
        // One edge first, so that an access taken at the current edge is already queued.
        @(posedge clk);
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_access(input logic op, input logic [salru_pkg::ADDR_W-1:0] address,
                               input bit pinned, input salru_pkg::out_item_t outcome);
        int gap;

        gap = (!steady && $urandom_range(0, 1) == 0) ? pause_length() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_data   <= salru_pkg::in_item_t'{op, address};
        pin_next  <= pinned;
        pin_value <= outcome;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Registers change only with the block idle: stop offering, drain, then write.
    task automatic program_cache(input logic [salru_pkg::CFG_DATA_W-1:0] off_v,
                                 input logic [salru_pkg::CFG_DATA_W-1:0] idx_v,
                                 input logic [salru_pkg::CFG_DATA_W-1:0] ways_v,
                                 input bit spare);
        logic [salru_pkg::CFG_IDX_W-1:0]  reg_sel [$];
        logic [salru_pkg::CFG_DATA_W-1:0] reg_val [$];

        reg_sel = '{salru_pkg::CFG_OFFSET_WIDTH, salru_pkg::CFG_INDEX_WIDTH,
                    salru_pkg::CFG_WAYS_IN_USE};
        reg_val = '{off_v, idx_v, ways_v};
        if (spare)
        begin
            reg_sel.push_back(CFG_SPARE);
            reg_val.push_back(salru_pkg::CFG_DATA_W'($urandom()));
        end
        in_valid <= 1'b0;
        settle();
        foreach (reg_sel[i])
        begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_sel[i];
            cfg_data  <= reg_val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!steady && $urandom_range(0, 3) == 0)
        begin
            out_ready <= 1'b0;
            hold_left <= pause_length() - 1;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        salru_pkg::out_item_t predicted;
        salru_pkg::out_item_t want;

        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (salru_pkg::cfg_reg_t'(cfg_index))
                    salru_pkg::CFG_OFFSET_WIDTH: off_bits  = cfg_data[salru_pkg::OFFW_W-1:0];
                    salru_pkg::CFG_INDEX_WIDTH:  idx_bits  = cfg_data[salru_pkg::IDXW_W-1:0];
                    salru_pkg::CFG_WAYS_IN_USE:  assoc_reg = cfg_data[salru_pkg::WAYS_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                predicted = access_cache(in_data);
                expected_outcomes.push_back(pin_next ? pin_value : predicted);
            end
            if (out_valid && out_ready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    $error("result transfer with nothing expected: hit %0d way %0d filled %0d",
                           out_data.hit, out_data.way, out_data.filled);
                    fault_count++;
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (out_data.hit !== want.hit)
                    begin
                        $error("hit: expected %0d, got %0d", want.hit, out_data.hit);
                        fault_count++;
                    end
                    if (out_data.way !== want.way)
                    begin
                        $error("way: expected %0d, got %0d", want.way, out_data.way);
                        fault_count++;
                    end
                    if (out_data.filled !== want.filled)
                    begin
                        $error("filled: expected %0d, got %0d", want.filled, out_data.filled);
                        fault_count++;
                    end
                end
            end
        end
    end

    // Covers the clearing pass after reset as well as every stall.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        plan_row_t                        row;
        logic [salru_pkg::CFG_DATA_W-1:0] off_v;
        logic [salru_pkg::CFG_DATA_W-1:0] idx_v;
        logic [salru_pkg::CFG_DATA_W-1:0] ways_v;
        logic                             op;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_ready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= salru_pkg::CFG_OFFSET_WIDTH;
        cfg_data  <= '0;
        pin_next  <= 1'b0;
        pin_value <= '0;
        steady    <= 1'b0;
        hold_left = 0;
        idle_cycles = 0;
        fault_count = 0;

        // One way per set at reset, so a second tag in a set evicts the first.
        directed_plan.push_back(pin(salru_pkg::OP_LOAD,  24'h000000,
                                    salru_pkg::out_item_t'{1'b0, 3'd0, 1'b1}));
        directed_plan.push_back(pin(salru_pkg::OP_LOAD,  24'h000003,
                                    salru_pkg::out_item_t'{1'b1, 3'd0, 1'b0}));
        directed_plan.push_back(pin(salru_pkg::OP_STORE, 24'hFFFFFF,
                                    salru_pkg::out_item_t'{1'b0, 3'd0, 1'b0}));
        directed_plan.push_back(pin(salru_pkg::OP_LOAD,  24'hFFFFFF,
                                    salru_pkg::out_item_t'{1'b0, 3'd0, 1'b1}));
        directed_plan.push_back(pin(salru_pkg::OP_STORE, 24'hFFFFFC,
                                    salru_pkg::out_item_t'{1'b1, 3'd0, 1'b0}));
        directed_plan.push_back(pin(salru_pkg::OP_LOAD,  24'h000100,
                                    salru_pkg::out_item_t'{1'b0, 3'd0, 1'b1}));
        directed_plan.push_back(pin(salru_pkg::OP_STORE, 24'h000000,
                                    salru_pkg::out_item_t'{1'b0, 3'd0, 1'b0}));
        directed_plan.push_back(setup(5'd2, 5'd6, 5'd8, 1'b0));
        directed_plan.push_back(pin(salru_pkg::OP_LOAD,  24'h000200,
                                    salru_pkg::out_item_t'{1'b0, 3'd1, 1'b1}));
        directed_plan.push_back(pin(salru_pkg::OP_LOAD,  24'h000100,
                                    salru_pkg::out_item_t'{1'b1, 3'd0, 1'b0}));
        directed_plan.push_back(pin(salru_pkg::OP_LOAD,  24'h000300,
                                    salru_pkg::out_item_t'{1'b0, 3'd2, 1'b1}));
        // Zero ways acts as one; the split swallows the whole address, so every tag is zero.
        directed_plan.push_back(setup(5'd23, 5'd10, 5'h10, 1'b0));
        directed_plan.push_back(pin(salru_pkg::OP_LOAD,  24'h800000,
                                    salru_pkg::out_item_t'{1'b0, 3'd0, 1'b1}));
        directed_plan.push_back(pin(salru_pkg::OP_LOAD,  24'h7FFFFF,
                                    salru_pkg::out_item_t'{1'b0, 3'd0, 1'b1}));
        directed_plan.push_back(setup(5'd31, 5'h1F, 5'd15, 1'b1));
        directed_plan.push_back(pin(salru_pkg::OP_STORE, 24'hABCDEF,
                                    salru_pkg::out_item_t'{1'b1, 3'd0, 1'b0}));
        directed_plan.push_back(acc(salru_pkg::OP_LOAD,  24'h123456));
        // A 15-bit index wraps onto the 1024 sets.
        directed_plan.push_back(setup(5'd0, 5'd15, 5'd8, 1'b0));
        directed_plan.push_back(acc(salru_pkg::OP_LOAD,  24'h000400));
        directed_plan.push_back(acc(salru_pkg::OP_LOAD,  24'h7FFFFF));
        directed_plan.push_back(setup(5'd0, 5'd0, 5'd8, 1'b0));
        directed_plan.push_back(acc(salru_pkg::OP_LOAD,  24'h000000));
        directed_plan.push_back(acc(salru_pkg::OP_STORE, 24'h5A5A5A));
        directed_plan.push_back(acc(salru_pkg::OP_LOAD,  24'hA5A5A5));
        directed_plan.push_back(acc(salru_pkg::OP_LOAD,  24'h5A5A5A));
        directed_plan.push_back(acc(salru_pkg::OP_STORE, 24'h000001));
        directed_plan.push_back(setup(5'd2, 5'd6, 5'd4, 1'b0));
        directed_plan.push_back(acc(salru_pkg::OP_STORE, 24'h000100));
        directed_plan.push_back(acc(salru_pkg::OP_LOAD,  24'h000600));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
        begin
            row = directed_plan[i];
            if (row.is_cfg)
                program_cache(row.off_v, row.idx_v, row.ways_v, row.spare);
            else
                send_access(row.op, row.address, row.pinned, row.outcome);
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    off_v = 5'd2;  idx_v = 5'd6;  ways_v = 5'd8;
                end
                1:
                begin
                    off_v = 5'd0;  idx_v = 5'd0;  ways_v = 5'd8;
                end
                2:
                begin
                    off_v = 5'd23; idx_v = 5'd10; ways_v = 5'd8;
                end
                3:
                begin
                    off_v = 5'd31; idx_v = 5'd15; ways_v = 5'd15;
                end
                4:
                begin
                    off_v = 5'd0;  idx_v = 5'd10; ways_v = 5'd1;
                end
                default:
                begin
                    off_v  = salru_pkg::CFG_DATA_W'($urandom_range(0, 26));
                    idx_v  = salru_pkg::CFG_DATA_W'($urandom_range(0, 31));
                    ways_v = salru_pkg::CFG_DATA_W'($urandom_range(0, 31));
                end
            endcase
            program_cache(off_v, idx_v, ways_v, phase == 5);
            steady <= (phase % 4 == 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (phase == 7 && n == ITEMS_PER_PHASE / 2)
                begin
                    in_valid <= 1'b0;
                    settle();
                end
                op = ($urandom_range(0, 9) < 6) ? salru_pkg::OP_LOAD : salru_pkg::OP_STORE;
                send_access(op, make_address(off_v, idx_v[salru_pkg::IDXW_W-1:0]), 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        settle();
        if (fault_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/salru_pkg.sv
rtl/salru_ram.sv
rtl/salru_ctrl.sv
rtl/salru_dpath.sv
rtl/set_assoc_cache_lru_tags_unit.sv
rtl/salru_checker.sv
dv/tb_top.sv
